// ===== rtl/ate_pkg.sv =====
// ----------------------------------------------------------------------------
// ate_pkg
// Shared types and constants for the animation time extrapolator.
// ----------------------------------------------------------------------------
package ate_pkg;

  localparam int unsigned TIME_W      = 32;
  localparam int unsigned DIV_STAGES  = 33;  // one quotient bit per stage
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned CFG_AW      = 5;

  localparam logic [TIME_W-1:0] FREQ_RESET  = 32'h0001_0000;
  localparam logic [TIME_W-1:0] PHASE_RESET = 32'h0000_0000;
  localparam logic [TIME_W-1:0] START_RESET = 32'h0000_0000;
  localparam logic [TIME_W-1:0] STOP_RESET  = 32'h0001_0000;

  typedef enum logic [1:0] {
    MODE_CYCLE     = 2'd0,
    MODE_REVERSE   = 2'd1,
    MODE_CONST     = 2'd2,
    MODE_CONST_ALT = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    REG_FREQ  = 3'd0,
    REG_PHASE = 3'd1,
    REG_START = 3'd2,
    REG_STOP  = 3'd3,
    REG_MODE  = 3'd4
  } reg_idx_t;

  // live configuration seen by front and back
  typedef struct packed {
    logic signed [TIME_W-1:0] freq;
    logic signed [TIME_W-1:0] phase;
    logic signed [TIME_W-1:0] start;
    logic signed [TIME_W-1:0] stop;
    mode_t                    mode;
  } cfg_t;

  // classified word handed from front to back
  typedef struct packed {
    logic              direct;   // result already known
    logic [TIME_W-1:0] value;    // direct result
    logic              sat;
    logic              neg;      // offset below start
    logic              rev;      // reverse mode
    logic [TIME_W:0]   mag;      // |time - start|
    logic [TIME_W-1:0] len;      // stop - start, positive
  } q_word_t;

endpackage

// ===== rtl/ate_if.sv =====
// ----------------------------------------------------------------------------
// ate_in_if / ate_out_if
// Valid/ready channels for input times and mapped results.
// ----------------------------------------------------------------------------
interface ate_in_if import ate_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [TIME_W-1:0] input_time;
  modport source (output valid, output input_time, input ready);
  modport sink   (input valid, input input_time, output ready);
endinterface

interface ate_out_if import ate_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [TIME_W-1:0] mapped_time;
  logic                     saturated;
  modport source (output valid, output mapped_time, output saturated, input ready);
  modport sink   (input valid, input mapped_time, input saturated, output ready);
endinterface

// ===== rtl/ate_front.sv =====
// ----------------------------------------------------------------------------
// ate_front
// Scales each time (multiply, floor shift, phase add, saturate) and sorts it
// into a direct result or a wrap job for the divider.
// ----------------------------------------------------------------------------
module ate_front import ate_pkg::*; #(
  parameter int unsigned DEPTH = QUEUE_DEPTH,
  parameter int unsigned CNT_W = $clog2(DEPTH + 1)
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  cfg_t                     cfg,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic signed [TIME_W-1:0] in_time,
  input  logic [CNT_W-1:0]         q_count,
  output logic                     push,
  output q_word_t                  push_word
);

  logic                       v1_r, v2_r;
  logic signed [2*TIME_W-1:0] prod_r;
  logic signed [TIME_W-1:0]   t_r;
  logic                       sat_r;
  logic signed [TIME_W+16:0]  sum;
  logic signed [TIME_W-1:0]   t_nxt;
  logic                       sat_nxt;
  logic [CNT_W+1:0]           used;
  logic                       accept;

  // credit: queue words plus words in flight must fit in the queue
  assign used     = (CNT_W + 2)'(q_count) + (CNT_W + 2)'(v1_r) + (CNT_W + 2)'(v2_r);
  assign in_ready = used < (CNT_W + 2)'(DEPTH);
  assign accept   = in_valid && in_ready;

  // floor shift, phase add, saturate
  always_comb begin
    sum = (TIME_W + 17)'(prod_r >>> 16) + (TIME_W + 17)'(cfg.phase);
    if (sum > (TIME_W + 17)'(32'sh7FFF_FFFF)) begin
      t_nxt   = 32'sh7FFF_FFFF;
      sat_nxt = 1'b1;
    end else if (sum < -(TIME_W + 17)'(33'sh0_8000_0000)) begin
      t_nxt   = 32'sh8000_0000;
      sat_nxt = 1'b1;
    end else begin
      t_nxt   = sum[TIME_W-1:0];
      sat_nxt = 1'b0;
    end
  end

  // pipeline registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= accept;
      v2_r <= v1_r;
    end
    prod_r <= (2*TIME_W)'(cfg.freq) * (2*TIME_W)'(in_time);
    t_r    <= t_nxt;
    sat_r  <= sat_nxt;
  end

  // classify
  logic signed [TIME_W:0] d;
  logic signed [TIME_W:0] len;
  logic                   outside, cyc;
  always_comb begin
    d       = (TIME_W + 1)'(t_r) - (TIME_W + 1)'(cfg.start);
    len     = (TIME_W + 1)'(cfg.stop) - (TIME_W + 1)'(cfg.start);
    outside = (t_r < cfg.start) || (t_r > cfg.stop);
    cyc     = (cfg.mode == MODE_CYCLE) || (cfg.mode == MODE_REVERSE);
    push_word.sat    = sat_r;
    push_word.neg    = d[TIME_W];
    push_word.rev    = (cfg.mode == MODE_REVERSE);
    push_word.mag    = d[TIME_W] ? (TIME_W + 1)'(-d) : d;
    push_word.len    = len[TIME_W-1:0];
    push_word.direct = 1'b1;
    push_word.value  = t_r;
    if (outside) begin
      if (cyc) begin
        if (len <= 0) push_word.value = cfg.start;
        else          push_word.direct = 1'b0;
      end else if (t_r < cfg.start) begin
        push_word.value = cfg.start;
      end else if (t_r > cfg.stop) begin
        push_word.value = cfg.stop;
      end
    end
  end

  assign push = v2_r;

endmodule

// ===== rtl/ate_queue.sv =====
// ----------------------------------------------------------------------------
// ate_queue
// Short FIFO between front and back.
// ----------------------------------------------------------------------------
module ate_queue import ate_pkg::*; #(
  parameter int unsigned DEPTH = QUEUE_DEPTH,
  parameter int unsigned CNT_W = $clog2(DEPTH + 1),
  parameter int unsigned IDX_W = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  q_word_t          push_word,
  input  logic             pop,
  output logic             empty,
  output q_word_t          head,
  output logic [CNT_W-1:0] count
);

  q_word_t          mem_r [DEPTH];
  logic [IDX_W-1:0] wr_r, rd_r;
  logic [CNT_W-1:0] cnt_r;

  assign empty = (cnt_r == '0);
  assign head  = mem_r[rd_r];
  assign count = cnt_r;

  function automatic logic [IDX_W-1:0] bump(input logic [IDX_W-1:0] p);
    return (p == IDX_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wr_r <= bump(wr_r);
      if (pop)  rd_r <= bump(rd_r);
      cnt_r <= cnt_r + CNT_W'(push) - CNT_W'(pop);
    end
    if (push) mem_r[wr_r] <= push_word;
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && !pop && cnt_r == CNT_W'(DEPTH)))
    else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && empty))
    else $error("queue underflow");
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(DEPTH))
    else $error("queue count out of range");

endmodule

// ===== rtl/ate_back.sv =====
// ----------------------------------------------------------------------------
// ate_back
// Pipelined restoring divider (one quotient bit per stage) for floor-modulo
// wrap, then final select into the output register.
// ----------------------------------------------------------------------------
module ate_back import ate_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  cfg_t                     cfg,
  input  logic                     q_empty,
  input  q_word_t                  q_head,
  output logic                     pop,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [TIME_W-1:0] out_time,
  output logic                     out_sat
);

  typedef struct packed {
    logic              valid;
    q_word_t           w;
    logic [TIME_W-1:0] rem;
    logic              qlsb;
  } stage_t;

  stage_t            st_r  [DIV_STAGES+1];
  stage_t            st_nxt[DIV_STAGES+1];
  logic              ovalid_r;
  logic [TIME_W-1:0] otime_r;
  logic              osat_r;
  logic              adv;

  // whole pipeline moves together when the output can take a word
  assign adv = !ovalid_r || out_ready;
  assign pop = adv && !q_empty;

  // divider stages: shift in next dividend bit, compare, subtract
  logic [TIME_W:0] sh  [DIV_STAGES];
  logic [TIME_W:0] dif [DIV_STAGES];
  always_comb begin
    st_nxt[0].valid = !q_empty;
    st_nxt[0].w     = q_head;
    st_nxt[0].rem   = '0;
    st_nxt[0].qlsb  = 1'b0;
    for (int i = 0; i < DIV_STAGES; i++) begin
      sh[i]  = {st_r[i].rem, st_r[i].w.mag[TIME_W]};
      dif[i] = sh[i] - {1'b0, st_r[i].w.len};
      st_nxt[i+1]       = st_r[i];
      st_nxt[i+1].w.mag = {st_r[i].w.mag[TIME_W-1:0], 1'b0};
      st_nxt[i+1].qlsb  = !dif[i][TIME_W];
      st_nxt[i+1].rem   = dif[i][TIME_W] ? sh[i][TIME_W-1:0] : dif[i][TIME_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i <= DIV_STAGES; i++) begin
      if (!rst_n)   st_r[i].valid <= 1'b0;
      else if (adv) st_r[i].valid <= st_nxt[i].valid;
      if (adv) begin
        st_r[i].w    <= st_nxt[i].w;
        st_r[i].rem  <= st_nxt[i].rem;
        st_r[i].qlsb <= st_nxt[i].qlsb;
      end
    end
  end

  // floor correction and mode select
  stage_t            lst;
  logic              fix, odd;
  logic [TIME_W-1:0] r, res;
  always_comb begin
    lst = st_r[DIV_STAGES];
    fix = lst.w.neg && (lst.rem != '0);
    r   = fix ? lst.w.len - lst.rem : lst.rem;
    odd = lst.qlsb ^ fix;
    if (lst.w.direct)          res = lst.w.value;
    else if (lst.w.rev && odd) res = cfg.stop - r;
    else                       res = cfg.start + r;
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n)   ovalid_r <= 1'b0;
    else if (adv) ovalid_r <= lst.valid;
    if (adv) begin
      otime_r <= res;
      osat_r  <= lst.w.sat;
    end
  end

  assign out_valid = ovalid_r;
  assign out_time  = otime_r;
  assign out_sat   = osat_r;

  a_last_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    adv && lst.valid |=> ovalid_r)
    else $error("finished word not presented");
  a_pop_enters: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> st_r[0].valid)
    else $error("popped word lost");

endmodule

// ===== rtl/animation_time_extrapolator.sv =====
// ----------------------------------------------------------------------------
// animation_time_extrapolator
// Scales an input time and maps it into the [start, stop] window by cycle,
// reverse or clamp extrapolation.
// ----------------------------------------------------------------------------
//   channel | dir | handshake      | word
//   in_ch   | in  | valid/ready    | input_time
//   out_ch  | out | valid/ready    | mapped_time, saturated
//   cfg_*   | in  | APB, 5 regs    | frequency..extrapolation_mode
//
// One word per cycle sustained while out_ch.ready holds; out_ch.valid rises once
// the accepted word has passed 2 front stages, one queue slot, entry register,
// the 33-stage restoring divider and the output register.
// Reset is synchronous, active low; registers return to defaults.
// An output stall freezes the back pipeline; the front keeps running into the
// queue by credit and drops in_ch.ready when the queue would fill.
// ----------------------------------------------------------------------------
module animation_time_extrapolator import ate_pkg::*; #(
  parameter int unsigned DEPTH = QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  ate_in_if.sink             in_ch,
  ate_out_if.source          out_ch,
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [CFG_AW-1:0]  cfg_paddr,
  input  logic [31:0]        cfg_pwdata,
  output logic [31:0]        cfg_prdata,
  output logic               cfg_pready
);

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [TIME_W-1:0] freq_r, phase_r, start_r, stop_r;
  mode_t             mode_r;
  reg_idx_t          idx;
  logic              wr;
  cfg_t              cfg;

  assign cfg_pready = 1'b1;
  assign idx        = reg_idx_t'(cfg_paddr[CFG_AW-1:2]);
  assign wr         = cfg_psel && cfg_penable && cfg_pwrite;

  // register file
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      freq_r  <= FREQ_RESET;
      phase_r <= PHASE_RESET;
      start_r <= START_RESET;
      stop_r  <= STOP_RESET;
      mode_r  <= MODE_CONST;
    end else if (wr) begin
      unique case (idx)
        REG_FREQ:  freq_r  <= cfg_pwdata;
        REG_PHASE: phase_r <= cfg_pwdata;
        REG_START: start_r <= cfg_pwdata;
        REG_STOP:  stop_r  <= cfg_pwdata;
        REG_MODE:  mode_r  <= mode_t'(cfg_pwdata[1:0]);
        default:   ;
      endcase
    end
  end

  // readback
  always_comb begin
    unique case (idx)
      REG_FREQ:  cfg_prdata = freq_r;
      REG_PHASE: cfg_prdata = phase_r;
      REG_START: cfg_prdata = start_r;
      REG_STOP:  cfg_prdata = stop_r;
      REG_MODE:  cfg_prdata = {30'd0, mode_r};
      default:   cfg_prdata = '0;
    endcase
  end

  assign cfg.freq  = freq_r;
  assign cfg.phase = phase_r;
  assign cfg.start = start_r;
  assign cfg.stop  = stop_r;
  assign cfg.mode  = mode_r;

  logic             push, pop, q_empty;
  q_word_t          push_word, q_head;
  logic [CNT_W-1:0] q_count;

  ate_front #(.DEPTH(DEPTH), .CNT_W(CNT_W)) u_front (
    .clk, .rst_n, .cfg,
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .in_time  (in_ch.input_time),
    .q_count, .push, .push_word
  );

  ate_queue #(.DEPTH(DEPTH), .CNT_W(CNT_W)) u_queue (
    .clk, .rst_n, .push, .push_word, .pop,
    .empty (q_empty),
    .head  (q_head),
    .count (q_count)
  );

  ate_back u_back (
    .clk, .rst_n, .cfg, .q_empty, .q_head, .pop,
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_time  (out_ch.mapped_time),
    .out_sat   (out_ch.saturated)
  );

endmodule

// ===== tb/tb_animation_time_extrapolator.sv =====
// ----------------------------------------------------------------------------
// tb_animation_time_extrapolator
// Drives input times through the extrapolator under a series of window,
// scale and mode settings and checks every mapped word against a built-in
// prediction. Both channels idle at random, the receiver once holds off long
// enough to back the block up, and the registers are rewritten between
// phases once the block has drained.
// ----------------------------------------------------------------------------
module tb_animation_time_extrapolator;
  import ate_pkg::*;

  typedef struct {
    logic [TIME_W-1:0] mapped;
    logic              sat;
  } mapped_word_t;

  typedef struct {
    logic [TIME_W-1:0] freq;
    logic [TIME_W-1:0] phase;
    logic [TIME_W-1:0] start;
    logic [TIME_W-1:0] stop;
    mode_t             mode;
  } setting_t;

  // Tracks the register copy and the mapped words still owed by the block
  class time_map_board;
    logic signed [TIME_W-1:0] freq, phase, start, stop;
    mode_t                    mode;
    mapped_word_t             owed[$];
    int                       errors;

    function new();
      freq = FREQ_RESET; phase = PHASE_RESET;
      start = START_RESET; stop = STOP_RESET;
      mode = MODE_CONST; errors = 0;
    endfunction

    function void set_reg(reg_idx_t idx, logic [31:0] v);
      case (idx)
        REG_FREQ:  freq  = v;
        REG_PHASE: phase = v;
        REG_START: start = v;
        REG_STOP:  stop  = v;
        REG_MODE:  mode  = mode_t'(v[1:0]);
        default: ;
      endcase
    endfunction

    task report(string what);
      $display("[%0t] mismatch: %s", $realtime, what);
      errors++;
    endtask

    // scale, saturate, then fold into the window
    function void note_input(logic signed [TIME_W-1:0] x);
      longint t, s, e, len, d, q, r, res;
      mapped_word_t w;
      t = ((longint'(freq) * longint'(x)) >>> 16) + longint'(phase);
      w.sat = 1'b0;
      if (t > 64'sd2147483647) begin
        t = 64'sd2147483647; w.sat = 1'b1;
      end
      if (t < -64'sd2147483648) begin
        t = -64'sd2147483648; w.sat = 1'b1;
      end
      s = longint'(start);
      e = longint'(stop);
      if (t >= s && t <= e) begin
        res = t;
      end else if (mode == MODE_CYCLE || mode == MODE_REVERSE) begin
        len = e - s;
        if (len <= 0) begin
          res = s;
        end else begin
          d = t - s;
          q = d / len;
          r = d % len;
          if (r < 0) begin
            r += len; q -= 1;
          end
          if (mode == MODE_CYCLE || q[0] == 1'b0) res = s + r;
          else res = e - r;
        end
      end else begin
        if (t < s) res = s;
        else if (t > e) res = e;
        else res = t;
      end
      w.mapped = res[TIME_W-1:0];
      owed.push_back(w);
    endfunction

    task check_word(logic [TIME_W-1:0] mapped, logic sat);
      mapped_word_t w;
      if (owed.size() == 0) begin
        report($sformatf("unexpected word mapped=%h sat=%b", mapped, sat));
      end else begin
        w = owed.pop_front();
        if (mapped !== w.mapped)
          report($sformatf("mapped_time %h, want %h", mapped, w.mapped));
        if (sat !== w.sat)
          report($sformatf("saturated %b, want %b", sat, w.sat));
      end
    endtask

    function int pending();
      return owed.size();
    endfunction
  endclass

  logic              clk;
  logic              rst_n;
  logic              cfg_psel, cfg_penable, cfg_pwrite;
  logic [CFG_AW-1:0] cfg_paddr;
  logic [31:0]       cfg_pwdata, cfg_prdata;
  logic              cfg_pready;

  ate_in_if  in_if();
  ate_out_if out_if();

  animation_time_extrapolator dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_if), .out_ch(out_if),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  time_map_board board = new();
  int  sent = 0;
  bit  calm = 0;       // no idling in the closing stretch
  bit  hold_req = 0;   // asks the receiver for one long hold-off
  int  quiet = 0;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Receiver: take words, stall in bursts, honor a long hold-off
  initial begin
    int burst, hold;
    burst = 0; hold = 0;
    out_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (out_if.valid && out_if.ready)
        board.check_word(out_if.mapped_time, out_if.saturated);
      if (hold_req) begin
        hold_req = 0; hold = 300;
      end
      if (!calm && burst == 0 && $urandom_range(0, 9) == 0)
        burst = $urandom_range(1, 18);
      out_if.ready <= rst_n && hold == 0 && burst == 0;
      if (hold > 0) hold--;
      if (burst > 0) burst--;
    end
  end

  // Watchdog on cycles with no handshake of any kind
  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) || cfg_psel)
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet >= 3000) begin
      $display("simulation failed");
      $finish;
    end
  end

  // setup, access, then idle before the next transfer
  task automatic cfg_write(reg_idx_t idx, logic [31:0] v);
    cfg_psel <= 1'b1; cfg_penable <= 1'b0; cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00}; cfg_pwdata <= v;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel <= 1'b0; cfg_penable <= 1'b0; cfg_pwrite <= 1'b0;
    board.set_reg(idx, v);
    @(posedge clk);
  endtask

  // Wait for every owed word, then rewrite all registers
  task automatic apply_setting(setting_t st);
    in_if.valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_write(REG_FREQ, st.freq);
    cfg_write(REG_PHASE, st.phase);
    cfg_write(REG_START, st.start);
    cfg_write(REG_STOP, st.stop);
    cfg_write(REG_MODE, {30'd0, st.mode});
  endtask

  task automatic send_time(logic [TIME_W-1:0] x);
    in_if.valid <= 1'b1;
    in_if.input_time <= x;
    do @(posedge clk); while (!in_if.ready);
    board.note_input(x);
    sent++;
    calm = (sent >= 600);
    if (!calm && $urandom_range(0, 7) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
  endtask

  function automatic logic [TIME_W-1:0] pick_time();
    logic [TIME_W-1:0] edges[6] = '{32'h7fff_ffff, 32'h8000_0000, 32'h0,
                                    32'hffff_ffff, 32'h1, 32'h0001_0000};
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return edges[$urandom_range(0, 5)];
      default: return $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
    endcase
  endfunction

  function automatic setting_t random_setting();
    setting_t st;
    logic [TIME_W-1:0] scales[5] = '{32'h0001_0000, 32'h0000_8000, 32'h0002_0000,
                                     32'hffff_0000, 32'h0};
    st.freq  = ($urandom_range(0, 4) == 0) ? $urandom : scales[$urandom_range(0, 4)];
    st.phase = ($urandom_range(0, 5) == 0) ? $urandom
                                           : $urandom_range(0, 32'h40000) - 32'h20000;
    st.start = $urandom_range(0, 32'h80000) - 32'h40000;
    st.stop  = st.start + $urandom_range(0, 32'h30000) - 32'h4000;
    st.mode  = mode_t'($urandom_range(0, 3));
    return st;
  endfunction

  initial begin
    setting_t plan[10];
    logic [TIME_W-1:0] firsts[8] = '{32'h0, 32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff,
                                     32'h1, 32'h0000_8000, 32'h0001_0000, 32'h0001_0001};
    rst_n = 1'b0;
    in_if.valid = 1'b0; in_if.input_time = '0;
    cfg_psel = 1'b0; cfg_penable = 1'b0; cfg_pwrite = 1'b0;
    cfg_paddr = '0; cfg_pwdata = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: unit window, clamp
    foreach (firsts[i]) send_time(firsts[i]);

    // saturation both ways, extreme registers
    plan[0] = '{32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, MODE_CONST};
    plan[1] = '{32'h8000_0000, 32'h8000_0000, 32'h0, 32'h0001_0000, MODE_CYCLE};
    // cycle and reverse over a 1.5 window, offset start
    plan[2] = '{32'h0001_0000, 32'h0, 32'hffff_0000, 32'h0000_8000, MODE_CYCLE};
    plan[3] = '{32'h0001_0000, 32'h0000_4000, 32'hffff_0000, 32'h0000_8000, MODE_REVERSE};
    // inverted window: cycle, reverse, clamp
    plan[4] = '{32'h0001_0000, 32'h0, 32'h0002_0000, 32'h0001_0000, MODE_CYCLE};
    plan[5] = '{32'h0001_0000, 32'h0, 32'h0002_0000, 32'h0001_0000, MODE_REVERSE};
    plan[6] = '{32'h0001_0000, 32'h0, 32'h0002_0000, 32'h0001_0000, MODE_CONST_ALT};
    // empty window, reverse
    plan[7] = '{32'h0002_0000, 32'h0, 32'h0001_0000, 32'h0001_0000, MODE_REVERSE};
    // widest window and a one-step window
    plan[8] = '{32'h0001_0000, 32'h0, 32'h8000_0000, 32'h7fff_ffff, MODE_REVERSE};
    plan[9] = '{32'h0000_0100, 32'h0, 32'h0, 32'h1, MODE_REVERSE};

    foreach (plan[p]) begin
      apply_setting(plan[p]);
      if (p == 3) hold_req = 1;
      for (int i = 0; i < 8; i++) send_time(firsts[i]);
      for (int i = 0; i < 30; i++) send_time(pick_time());
    end

    while (sent < 700) begin
      apply_setting(random_setting());
      for (int i = 0; i < 40; i++) send_time(pick_time());
    end
    in_if.valid <= 1'b0;

    while (board.pending() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (board.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== animation_time_extrapolator.f =====
rtl/ate_pkg.sv
rtl/ate_if.sv
rtl/ate_front.sv
rtl/ate_queue.sv
rtl/ate_back.sv
rtl/animation_time_extrapolator.sv
tb/tb_animation_time_extrapolator.sv
